>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the timer and interrupt unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only while out of reset.
`define HTI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked on every clock edge, reset included.
`define HTI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HTI_ASSERT(lbl, clk, rst_n, prop)
`define HTI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hdl/hti_pkg.sv
// Types, codes and constants of the handheld timer and interrupt unit.
package hti_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [7:0] ADDR_DIV  = 8'h04;
  localparam logic [7:0] ADDR_TIMA = 8'h05;
  localparam logic [7:0] ADDR_TMA  = 8'h06;
  localparam logic [7:0] ADDR_TAC  = 8'h07;
  localparam logic [7:0] ADDR_IF   = 8'h0F;
  localparam logic [7:0] ADDR_IE   = 8'hFF;

  localparam logic [7:0] DIV_RESET    = 8'hAB;
  localparam logic [7:0] IF_RESET     = 8'hE1;
  localparam logic [7:0] IF_FIXED     = 8'hE0;
  localparam logic [7:0] TIMER_IRQ    = 8'h04;
  localparam logic [7:0] DIV_STEP     = 8'd64;
  localparam logic [8:0] PERIOD_RESET = 9'd248;

  localparam logic [6:0] VEC_VBLANK = 7'h40;
  localparam logic [6:0] VEC_STAT   = 7'h48;
  localparam logic [6:0] VEC_TIMER  = 7'h50;
  localparam logic [6:0] VEC_JOYPAD = 7'h60;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic       cpu_stopped;
    logic       master_enable;
    logic       cpu_halted;
    logic [4:0] raise_mask;
  } item_t;

  typedef struct packed {
    logic       wake;
    logic [6:0] irq_vector;
    logic       irq_take;
    logic [7:0] rdata;
  } result_t;

  function automatic logic [8:0] period_lut(input logic [1:0] sel);
    logic [8:0] p;
    case (sel)
      2'd0:    p = 9'd256;
      2'd1:    p = 9'd4;
      2'd2:    p = 9'd16;
      default: p = 9'd64;
    endcase
    return p;
  endfunction

endpackage

>>> hdl/hti_regs.sv
// Register file, divider, timer and interrupt flag logic; one beat per cycle while en is high.
module hti_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  hti_pkg::item_t  item,
  output hti_pkg::result_t res
);
  import hti_pkg::*;

  logic [7:0] div_prescale_r, div_prescale_nxt;
  logic [7:0] divider_r, divider_nxt;
  logic [7:0] tima_r, tima_nxt;
  logic [7:0] tma_r, tma_nxt;
  logic [7:0] tma_old_r, tma_old_nxt;
  logic       tma_written_r, tma_written_nxt;
  logic       timer_on_r, timer_on_nxt;
  logic [8:0] period_r, period_nxt;
  logic [8:0] tim_prescale_r, tim_prescale_nxt;
  logic [7:0] if_r, if_nxt;
  logic [7:0] ie_r, ie_nxt;

  always_comb begin
    logic [4:0] src;
    div_prescale_nxt = div_prescale_r;
    divider_nxt      = divider_r;
    tima_nxt         = tima_r;
    tma_nxt          = tma_r;
    tma_old_nxt      = tma_old_r;
    tma_written_nxt  = tma_written_r;
    timer_on_nxt     = timer_on_r;
    period_nxt       = period_r;
    tim_prescale_nxt = tim_prescale_r;
    if_nxt           = if_r;
    ie_nxt           = ie_r;
    res              = '0;
    src              = '0;
    case (item.cmd)
      CMD_TICK: begin
        div_prescale_nxt = div_prescale_r + 8'(div_prescale_r != 8'hFF);
        if (div_prescale_nxt >= DIV_STEP && !item.cpu_stopped) begin
          div_prescale_nxt = div_prescale_nxt - DIV_STEP;
          divider_nxt      = divider_r + 8'd1;
        end
        if (timer_on_r) begin
          tim_prescale_nxt = tim_prescale_r + 9'(tim_prescale_r != 9'h1FF);
          if (tim_prescale_nxt >= period_r) begin
            tima_nxt = tima_r + 8'd1;
            if (tima_nxt == 8'd0) begin
              if_nxt   = if_nxt | TIMER_IRQ;
              tima_nxt = tma_written_r ? tma_old_r : tma_r;
            end
            tim_prescale_nxt = tim_prescale_nxt - period_r;
          end
        end
        tma_written_nxt = 1'b0;
        if_nxt = if_nxt | {3'b000, item.raise_mask};
        src = {if_nxt[4], 1'b0, if_nxt[2:0]} & {ie_r[4], 1'b0, ie_r[2:0]};
        if (item.master_enable) begin
          if (src[0]) begin
            res.irq_vector = VEC_VBLANK;
            if_nxt[0]      = 1'b0;
          end else if (src[1]) begin
            res.irq_vector = VEC_STAT;
            if_nxt[1]      = 1'b0;
          end else if (src[2]) begin
            res.irq_vector = VEC_TIMER;
            if_nxt[2]      = 1'b0;
          end else if (src[4]) begin
            res.irq_vector = VEC_JOYPAD;
            if_nxt[4]      = 1'b0;
          end
          res.irq_take = |src;
        end else begin
          res.wake = item.cpu_halted && (|src);
        end
      end
      CMD_READ: begin
        case (item.reg_addr)
          ADDR_DIV:  res.rdata = divider_r;
          ADDR_TIMA: res.rdata = tima_r;
          ADDR_TMA:  res.rdata = tma_r;
          ADDR_IF:   res.rdata = if_r;
          ADDR_IE:   res.rdata = ie_r;
          default:   res.rdata = 8'd0;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_addr)
          ADDR_DIV:  divider_nxt = 8'd0;
          ADDR_TIMA: tima_nxt = item.wdata;
          ADDR_TMA: begin
            tma_old_nxt     = tma_r;
            tma_nxt         = item.wdata;
            tma_written_nxt = 1'b1;
          end
          ADDR_TAC: begin
            timer_on_nxt = item.wdata[2];
            period_nxt   = period_lut(item.wdata[1:0]);
          end
          ADDR_IF:   if_nxt = item.wdata | IF_FIXED;
          ADDR_IE:   ie_nxt = item.wdata;
          default:   ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_prescale_r <= 8'd0;
      divider_r      <= DIV_RESET;
      tima_r         <= 8'd0;
      tma_r          <= 8'd0;
      tma_old_r      <= 8'd0;
      tma_written_r  <= 1'b0;
      timer_on_r     <= 1'b0;
      period_r       <= PERIOD_RESET;
      tim_prescale_r <= 9'd0;
      if_r           <= IF_RESET;
      ie_r           <= 8'd0;
    end else if (en) begin
      div_prescale_r <= div_prescale_nxt;
      divider_r      <= divider_nxt;
      tima_r         <= tima_nxt;
      tma_r          <= tma_nxt;
      tma_old_r      <= tma_old_nxt;
      tma_written_r  <= tma_written_nxt;
      timer_on_r     <= timer_on_nxt;
      period_r       <= period_nxt;
      tim_prescale_r <= tim_prescale_nxt;
      if_r           <= if_nxt;
      ie_r           <= ie_nxt;
    end
  end

endmodule

>>> hdl/handheld_timer_interrupt_unit_top.sv
// A result beat is registered in the output register, or in the skid entry on a stall.
// Throughput: one beat per cycle while in_tready is high; all register, divider, timer
// and flag updates settle in one short combinational pass into the state registers.
// An output register plus one skid entry take one more beat after the output
// stalls; the input then waits until the skid entry drains.
// Reset (rst_n low, synchronous) loads DIV 0xAB, IF 0xE1, timer period 248, rest zero.
`include "assert_macros.svh"
module handheld_timer_interrupt_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // reg_addr[7:0], wdata[15:8], cpu_stopped[16], master_enable[17],
  // cpu_halted[18], raise_mask[23:19]
  input  logic [23:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // rdata[7:0], irq_take[8], irq_vector[15:9], wake[16], zero[23:17]
  output logic [23:0] out_tdata
);
  import hti_pkg::*;

  item_t   item;
  result_t res;
  result_t out_r, skid_r;
  logic    out_v_r, skid_v_r;
  logic    in_fire, out_fire;
  logic    vec_ok, res_quiet;

  assign item = '{cmd: in_tuser, reg_addr: in_tdata[7:0], wdata: in_tdata[15:8],
                  cpu_stopped: in_tdata[16], master_enable: in_tdata[17],
                  cpu_halted: in_tdata[18], raise_mask: in_tdata[23:19]};

  assign in_tready = ~skid_v_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_v_r & out_tready;

  hti_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_fire),
    .item  (item),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_fire) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_r.wake, out_r.irq_vector, out_r.irq_take, out_r.rdata};

  assign vec_ok    = out_r.irq_vector inside {VEC_VBLANK, VEC_STAT, VEC_TIMER, VEC_JOYPAD};
  assign res_quiet = !res.irq_take && !res.wake && (res.irq_vector == 7'd0);

  `HTI_ASSERT(a_skid_needs_out, clk, rst_n, skid_v_r |-> out_v_r)
  `HTI_ASSERT(a_take_vector, clk, rst_n, (out_v_r && out_r.irq_take) |-> vec_ok)
  `HTI_ASSERT(a_take_not_wake, clk, rst_n, out_v_r |-> !(out_r.irq_take && out_r.wake))
  `HTI_ASSERT(a_nontick_quiet, clk, rst_n, (in_fire && in_tuser != CMD_TICK) |-> res_quiet)

endmodule
